// ----- src/wbr_pkg.sv -----
// Package: shared widths, constants and register indexes for the word repacker.
`default_nettype none
package wbr_pkg;

  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned WORD_DATA_BITS = 14;
  localparam int unsigned PENDING_MAX    = 7;
  localparam int unsigned PEND_W         = 3;
  localparam int unsigned ACC_W          = WORD_DATA_BITS + PENDING_MAX;
  localparam int unsigned CFG_DATA_W     = 32;
  localparam int unsigned CFG_ADDR_W     = 3;

  typedef enum logic {
    REG_SWAP_BYTES  = 1'b0,
    REG_PACKED_MODE = 1'b1
  } reg_idx_t;

  // Results still to be delivered from the output stage.
  typedef enum logic [1:0] {
    OQ_EMPTY = 2'd0,
    OQ_ONE   = 2'd1,
    OQ_TWO   = 2'd2
  } oq_cnt_t;

endpackage : wbr_pkg
`default_nettype wire

// ----- src/wbr_in_if.sv -----
// Interface: input word channel, two raw bytes per request.
`default_nettype none
interface wbr_in_if
  import wbr_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] first_byte;
  logic [BYTE_W-1:0] second_byte;

  modport source (output valid, output first_byte, output second_byte, input ready);
  modport sink   (input valid, input first_byte, input second_byte, output ready);
endinterface : wbr_in_if
`default_nettype wire

// ----- src/wbr_out_if.sv -----
// Interface: output byte channel with end-of-word flag.
`default_nettype none
interface wbr_out_if
  import wbr_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_of_word;

  modport source (output valid, output out_byte, output last_of_word, input ready);
  modport sink   (input valid, input out_byte, input last_of_word, output ready);
endinterface : wbr_out_if
`default_nettype wire

// ----- src/word14_to_byte_repacker_unit.sv -----
// Top level: 16-bit word to byte repacker with optional 14-bit packing.
//
// Usage:
//   in_ch  : one request per 16-bit word, given as first_byte (even offset)
//            and second_byte (odd offset), valid/ready handshake.
//   out_ch : one byte per request; last_of_word marks the final byte of a word.
//   cfg_*  : APB-style registers. Offset 0x0 swap_bytes, offset 0x4
//            packed_14bit_mode, bit 0 of each. Write only while idle.
// Plain mode gives two bytes per word; packed mode gives one or two, taking
// the low 14 bits MSB-first onto up to 7 pending bits.
// The first byte of a word appears in the cycle after the word is taken.
// The single-byte output channel drains the two-entry result stage one byte
// at a time, so a word is done once its last byte leaves. A new word is taken
// in the cycle the last byte leaves.
// Reset: clears both registers, the pending bits and the result stage.
// Stall: while out_ch.ready is low the current byte holds and no further
// word is taken once the result stage is occupied.
`default_nettype none
module word14_to_byte_repacker_unit
  import wbr_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  wbr_in_if.sink                in_ch,
  wbr_out_if.source             out_ch,
  input  wire                   cfg_psel,
  input  wire                   cfg_penable,
  input  wire                   cfg_pwrite,
  input  wire  [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire  [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic                 swap_r;
  logic                 packed_r;
  logic [PENDING_MAX-1:0] lb_r;
  logic [PEND_W-1:0]    lc_r;
  oq_cnt_t              oq_cnt_r, oq_cnt_nxt;
  logic [BYTE_W-1:0]    oq_b0_r, oq_b0_nxt;
  logic [BYTE_W-1:0]    oq_b1_r, oq_b1_nxt;
  logic [PENDING_MAX-1:0] lb_nxt;
  logic [PEND_W-1:0]    lc_nxt;

  logic                 cfg_wr;
  reg_idx_t             cfg_idx;
  logic                 in_fire, out_fire;

  logic [BYTE_W-1:0]    even_b, odd_b;
  logic [WORD_DATA_BITS-1:0] word14;
  logic [PENDING_MAX-1:0] lb_used;
  logic [ACC_W-1:0]     acc;
  logic [PEND_W:0]      sh0;
  logic [PEND_W-1:0]    sh1;
  logic                 two_out;
  logic [BYTE_W-1:0]    pk_b0, pk_b1;
  logic [PEND_W-1:0]    rem_cnt;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_r   <= 1'b0;
      packed_r <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SWAP_BYTES:  swap_r   <= cfg_pwdata[0];
        REG_PACKED_MODE: packed_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SWAP_BYTES:  cfg_prdata = {{(CFG_DATA_W-1){1'b0}}, swap_r};
      REG_PACKED_MODE: cfg_prdata = {{(CFG_DATA_W-1){1'b0}}, packed_r};
      default:         cfg_prdata = '0;
    endcase
  end

  // Handshakes
  assign in_ch.ready = (oq_cnt_r == OQ_EMPTY) || ((oq_cnt_r == OQ_ONE) && out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_ch.valid && out_ch.ready;

  // Word assembly and repacking
  assign even_b  = swap_r ? in_ch.second_byte : in_ch.first_byte;
  assign odd_b   = swap_r ? in_ch.first_byte  : in_ch.second_byte;
  assign word14  = {odd_b[WORD_DATA_BITS-BYTE_W-1:0], even_b};
  assign lb_used = lb_r & ~({PENDING_MAX{1'b1}} << lc_r);
  assign acc     = {lb_used, word14};
  assign sh0     = {1'b0, lc_r} + (PEND_W+1)'(WORD_DATA_BITS - BYTE_W);
  assign two_out = (lc_r >= PEND_W'(2));
  assign sh1     = lc_r - PEND_W'(2);
  assign pk_b0   = BYTE_W'(acc >> sh0);
  assign pk_b1   = BYTE_W'(acc >> sh1);
  assign rem_cnt = two_out ? sh1 : PEND_W'(sh0);

  always_comb begin
    oq_cnt_nxt = oq_cnt_r;
    oq_b0_nxt  = oq_b0_r;
    oq_b1_nxt  = oq_b1_r;
    lb_nxt     = lb_r;
    lc_nxt     = lc_r;
    if (in_fire) begin
      if (packed_r) begin
        lb_nxt = acc[PENDING_MAX-1:0];
        lc_nxt = rem_cnt;
        if (two_out) begin
          oq_cnt_nxt = OQ_TWO;
          oq_b0_nxt  = pk_b0;
          oq_b1_nxt  = pk_b1;
        end else begin
          oq_cnt_nxt = OQ_ONE;
          oq_b1_nxt  = pk_b0;
        end
      end else begin
        oq_cnt_nxt = OQ_TWO;
        oq_b0_nxt  = even_b;
        oq_b1_nxt  = odd_b;
      end
    end else if (out_fire) begin
      oq_cnt_nxt = (oq_cnt_r == OQ_TWO) ? OQ_ONE : OQ_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_cnt_r <= OQ_EMPTY;
      lb_r     <= '0;
      lc_r     <= '0;
    end else begin
      oq_cnt_r <= oq_cnt_nxt;
      lb_r     <= lb_nxt;
      lc_r     <= lc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oq_b0_r <= oq_b0_nxt;
    oq_b1_r <= oq_b1_nxt;
  end

  // Output stage
  assign out_ch.valid        = (oq_cnt_r != OQ_EMPTY);
  assign out_ch.out_byte     = (oq_cnt_r == OQ_TWO) ? oq_b0_r : oq_b1_r;
  assign out_ch.last_of_word = (oq_cnt_r == OQ_ONE);

  // Assertions
  a_oq_legal: assert property (@(posedge clk) disable iff (!rst_n)
    oq_cnt_r == OQ_EMPTY || oq_cnt_r == OQ_ONE || oq_cnt_r == OQ_TWO)
    else $error("result stage count out of range");

  a_take_only_when_draining: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (oq_cnt_r == OQ_EMPTY || (oq_cnt_r == OQ_ONE && out_fire)))
    else $error("request taken while results still pending");

  a_plain_two_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !packed_r) |=> (oq_cnt_r == OQ_TWO))
    else $error("plain word did not queue two bytes");

  a_plain_keeps_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !packed_r) |=> $stable(lc_r))
    else $error("plain word changed pending bit count");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.out_byte)))
    else $error("stalled byte changed");

endmodule : word14_to_byte_repacker_unit
`default_nettype wire

// ----- dv/word14_to_byte_repacker_unit_tb.sv -----
// Testbench: random and directed word traffic with a byte-level repacking predictor.
`timescale 1ns / 1ps
module word14_to_byte_repacker_unit_tb;
  import wbr_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_WORDS   = 450;

  typedef struct packed {
    logic [BYTE_W-1:0] even_b;
    logic [BYTE_W-1:0] odd_b;
  } word_req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } byte_req_t;

  logic clk;
  logic rst_n;

  wbr_in_if  in_ch ();
  wbr_out_if out_ch ();

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  word14_to_byte_repacker_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  word_req_t pending_words[$];
  byte_req_t expected_bytes[$];

  logic        swap_on;
  logic        packed_on;
  logic [6:0]  pend_bits;
  logic [2:0]  pend_cnt;

  int unsigned errors;
  int unsigned words_taken;
  int unsigned packed_words;
  int unsigned bytes_checked;
  int unsigned settings_used;
  int unsigned quiet_cycles;
  int unsigned burst_left;
  int unsigned gap_left;
  logic [15:0] stall_pattern;
  logic [5:0]  stall_tick;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  task automatic repack_word(input logic [BYTE_W-1:0] b0, input logic [BYTE_W-1:0] b1);
    logic [BYTE_W-1:0] lo;
    logic [BYTE_W-1:0] hi;
    int unsigned       acc;
    int unsigned       n;
    lo = swap_on ? b1 : b0;
    hi = swap_on ? b0 : b1;
    if (!packed_on) begin
      expected_bytes.push_back('{data: lo, last: 1'b0});
      expected_bytes.push_back('{data: hi, last: 1'b1});
      return;
    end
    acc = ((pend_bits & ((1 << pend_cnt) - 1)) << WORD_DATA_BITS) | {hi[5:0], lo};
    n   = pend_cnt + WORD_DATA_BITS;
    if (n >= 2 * BYTE_W) begin
      expected_bytes.push_back('{data: BYTE_W'(acc >> (n - BYTE_W)), last: 1'b0});
      expected_bytes.push_back('{data: BYTE_W'(acc >> (n - 2 * BYTE_W)), last: 1'b1});
      n = n - 2 * BYTE_W;
    end else begin
      expected_bytes.push_back('{data: BYTE_W'(acc >> (n - BYTE_W)), last: 1'b1});
      n = n - BYTE_W;
    end
    pend_cnt  = 3'(n);
    pend_bits = 7'(acc & ((1 << n) - 1));
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_SWAP_BYTES:  swap_on = value[0];
      REG_PACKED_MODE: packed_on = value[0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_ch.valid || expected_bytes.size() != 0);
  endtask

  task automatic set_mode(input logic swap_val, input logic packed_val);
    wait_idle();
    repeat (2) @(posedge clk);
    write_reg(REG_SWAP_BYTES, {31'($urandom), swap_val});
    write_reg(REG_PACKED_MODE, {31'($urandom), packed_val});
    settings_used++;
  endtask

  function automatic void queue_word(input logic [BYTE_W-1:0] b0, input logic [BYTE_W-1:0] b1);
    pending_words.push_back('{even_b: b0, odd_b: b1});
  endfunction

  function automatic logic [BYTE_W-1:0] random_byte();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // sender: bursts of requests separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left  <= 0;
      gap_left    <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        repack_word(in_ch.first_byte, in_ch.second_byte);
        words_taken++;
        if (packed_on) packed_words++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0) begin
          gap_left    <= gap_left - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          word_req_t w;
          w = pending_words.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.first_byte  <= w.even_b;
          in_ch.second_byte <= w.odd_b;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 16);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall on a rotating pattern, never all low
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready  <= 1'b0;
      stall_tick     = '0;
      stall_pattern  = '1;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected byte %02h last %0b", $time, out_ch.out_byte,
                   out_ch.last_of_word);
          errors++;
        end else begin
          byte_req_t e;
          e = expected_bytes.pop_front();
          bytes_checked++;
          if (out_ch.out_byte !== e.data) begin
            $display("%0t: out_byte expected %02h actual %02h", $time, e.data, out_ch.out_byte);
            errors++;
          end
          if (out_ch.last_of_word !== e.last) begin
            $display("%0t: last_of_word expected %0b actual %0b", $time, e.last,
                     out_ch.last_of_word);
            errors++;
          end
        end
      end
      stall_tick = stall_tick + 1;
      if (stall_tick == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pattern = '1;
          1:       stall_pattern = 16'h0101;
          default: stall_pattern = 16'($urandom) | 16'h0001;
        endcase
      end
      out_ch.ready <= stall_pattern[stall_tick[3:0]];
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("word14_to_byte_repacker_unit_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned random_left;
    int unsigned n;
    int unsigned setting_idx;
    logic [1:0]  mode;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.first_byte  = '0;
    in_ch.second_byte = '0;
    out_ch.ready      = 1'b0;
    cfg_psel          = 1'b0;
    cfg_penable       = 1'b0;
    cfg_pwrite        = 1'b0;
    cfg_paddr         = '0;
    cfg_pwdata        = '0;
    swap_on           = 1'b0;
    packed_on         = 1'b0;
    pend_bits         = '0;
    pend_cnt          = '0;
    errors            = 0;
    words_taken       = 0;
    packed_words      = 0;
    bytes_checked     = 0;
    settings_used     = 0;
    quiet_cycles      = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    set_mode(1'b0, 1'b0);
    queue_word(8'h00, 8'hFF);
    queue_word(8'hFF, 8'h00);
    queue_word(8'hA5, 8'h3C);
    set_mode(1'b1, 1'b0);
    queue_word(8'h12, 8'h34);
    queue_word(8'hFF, 8'h00);
    // drop the top two word bits in packed mode
    set_mode(1'b0, 1'b1);
    queue_word(8'hFF, 8'hFF);
    queue_word(8'h00, 8'h00);
    queue_word(8'hFF, 8'h3F);
    queue_word(8'h00, 8'hC0);
    queue_word(8'h55, 8'hAA);
    queue_word(8'hFF, 8'hFF);
    set_mode(1'b1, 1'b1);
    queue_word(8'hC0, 8'h00);
    queue_word(8'h3F, 8'hFF);
    queue_word(8'hAA, 8'h55);
    // hold pending bits across a plain-mode stretch
    set_mode(1'b1, 1'b0);
    queue_word(8'h01, 8'h80);
    queue_word(8'h7E, 8'hE7);
    set_mode(1'b0, 1'b1);
    queue_word(8'hFF, 8'hFF);
    queue_word(8'h01, 8'h00);
    queue_word(8'h80, 8'h3F);

    random_left = RANDOM_WORDS;
    setting_idx = 0;
    while (random_left > 0) begin
      mode = (setting_idx < 4) ? 2'(setting_idx) : 2'($urandom_range(0, 3));
      n    = $urandom_range(10, 60);
      if (n > random_left) n = random_left;
      set_mode(mode[0], mode[1]);
      repeat (n) queue_word(random_byte(), random_byte());
      random_left = random_left - n;
      setting_idx++;
    end

    wait_idle();
    repeat (8) @(posedge clk);
    $display("Covered %0d words (%0d packed, %0d plain) over %0d register settings,",
             words_taken, packed_words, words_taken - packed_words, settings_used);
    $display("with %0d output bytes checked and %0d mismatches.", bytes_checked, errors);
    if (errors == 0) begin
      $display("word14_to_byte_repacker_unit_tb passed");
    end else begin
      $display("word14_to_byte_repacker_unit_tb failed");
    end
    $finish;
  end

endmodule : word14_to_byte_repacker_unit_tb

// ----- word14_to_byte_repacker_unit.f -----
src/wbr_pkg.sv
src/wbr_in_if.sv
src/wbr_out_if.sv
src/word14_to_byte_repacker_unit.sv
dv/word14_to_byte_repacker_unit_tb.sv
